// ===== rtl/chc_pkg.sv =====
`timescale 1ns / 1ps
// Package of the canonical Huffman encoder: sizes, codes and the command and status records.
package chc_pkg;

    // Alphabet and code sizes
    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 256;
    localparam int CODE_W       = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int FILL_W   = 3;
    localparam int STATUS_W = 2;

    // Stream word widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1 + STATUS_W;

    // Derived sizes
    localparam int MEM_DEPTH  = 2 ** SYM_W;
    localparam int CNT_W      = $clog2(NUM_SYMBOLS + 1);
    localparam int CNT_IDX_W  = $clog2(LEN_LIMIT);
    localparam int IDX_W      = (CNT_W > CNT_IDX_W) ? CNT_W : CNT_IDX_W;
    localparam int ACC_W      = CODE_W + BYTE_W - 1;
    localparam int TOT_W      = $clog2(ACC_W + 1);
    localparam int NB_W       = TOT_W - FILL_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_LEN_REFUSED = 2'd1,
        ST_NO_CODE     = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             sweep;
        logic             cnt_en;
        logic             sum_en;
        logic             asn_en;
        logic             enc_calc;
        logic             emit;
        logic             resp_push;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic enc_single;
        logic rem_one;
    } sts_t;

endpackage

// ===== rtl/chc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the canonical Huffman encoder.
module chc_ctrl import chc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  op_t  in_op,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CNT  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_ASN  = 7'b0001000,
        S_ENC  = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_RESP = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    idx_next   = '0;
                    unique case (in_op)
                        OP_LOAD, OP_FLUSH: state_next = S_RESP;
                        OP_BUILD:          state_next = S_CNT;
                        OP_ENCODE:         state_next = S_ENC;
                    endcase
                end
            end
            S_CNT: begin
                cmd.sweep  = 1'b1;
                cmd.cnt_en = (idx_reg != '0);
                if (idx_reg == IDX_W'(NUM_SYMBOLS)) begin
                    idx_next   = '0;
                    state_next = S_SUM;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_SUM: begin
                cmd.sum_en = 1'b1;
                if (idx_reg == IDX_W'(LEN_LIMIT - 1)) begin
                    idx_next   = '0;
                    state_next = S_ASN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ASN: begin
                cmd.sweep  = 1'b1;
                cmd.asn_en = (idx_reg != '0);
                if (idx_reg == IDX_W'(NUM_SYMBOLS)) begin
                    idx_next   = '0;
                    state_next = S_RESP;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ENC: begin
                cmd.enc_calc = 1'b1;
                state_next   = sts.enc_single ? S_RESP : S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.rem_one) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.resp_push = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/chc_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the canonical Huffman encoder: tables, code assignment, bit packer, output register.
module chc_dp import chc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  op_t               in_op,
    input  logic [SYM_W-1:0]  in_symbol,
    input  logic [LEN_W-1:0]  in_code_length,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_byte_valid,
    output status_t           out_status,
    output logic              out_last
);

    function automatic logic [CODE_W-1:0] rev_code(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] r;
        for (int i = 0; i < CODE_W; i++) begin
            r[i] = v[CODE_W-1-i];
        end
        return r;
    endfunction

    // Tables
    logic [LEN_W-1:0]     len_mem  [MEM_DEPTH];
    logic [CODE_W-1:0]    code_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] len_vld_reg;
    logic                 built_reg;

    // Registered read port
    logic [SYM_W-1:0]  rd_addr;
    logic [SYM_W-1:0]  addr_q_reg;
    logic [LEN_W-1:0]  len_q_reg;
    logic              len_vld_q_reg;
    logic [CODE_W-1:0] code_q_reg;

    // Build state
    logic [CNT_W-1:0]  cnt_reg [LEN_LIMIT];
    logic [CODE_W-1:0] nxt_reg [LEN_LIMIT];
    logic [CODE_W-1:0] run_reg;

    // Packer and result state
    logic [BYTE_W-1:0] buf_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [NB_W-1:0]   rem_reg;
    logic [BYTE_W-1:0] resp_byte_reg;
    logic              resp_bv_reg;
    status_t           resp_status_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_bv_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    // Combinational terms
    logic                 len_too_long;
    logic                 sym_in_range;
    logic                 len_we;
    logic [LEN_W-1:0]     len_eff;
    logic [LEN_W-1:0]     len_m1;
    logic [CNT_IDX_W-1:0] len_idx;
    logic [CNT_IDX_W-1:0] sum_k;
    logic [CNT_IDX_W-1:0] sum_km1;
    logic [CODE_W-1:0]    sum_val;
    logic [LEN_W:0]       rsh;
    logic [CODE_W-1:0]    code_wdata;
    logic [CODE_W:0]      mask_full;
    logic [CODE_W-1:0]    code_masked;
    logic [ACC_W-1:0]     enc_acc;
    logic [ACC_W-1:0]     enc_shift;
    logic [TOT_W-1:0]     enc_total;
    logic [NB_W-1:0]      enc_nb;
    logic                 push;

    assign len_too_long = (in_code_length > LEN_W'(LEN_LIMIT));
    assign sym_in_range = ({1'b0, in_symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
    assign len_we       = cmd.accept && (in_op == OP_LOAD) && !len_too_long && sym_in_range;
    assign rd_addr      = cmd.sweep ? SYM_W'(cmd.idx) : in_symbol;

    // A symbol never loaded since reset reads as length zero
    assign len_eff = len_vld_q_reg ? len_q_reg : '0;
    assign len_m1  = len_eff - LEN_W'(1);
    assign len_idx = len_m1[CNT_IDX_W-1:0];

    // First codes per length, one length a step
    assign sum_k   = cmd.idx[CNT_IDX_W-1:0];
    assign sum_km1 = sum_k - CNT_IDX_W'(1);
    assign sum_val = (sum_k == '0) ? '0 : ((run_reg + CODE_W'(cnt_reg[sum_km1])) << 1);

    // Code of the swept symbol, reversed within its length
    assign rsh        = (LEN_W + 1)'(CODE_W) - {1'b0, len_eff};
    assign code_wdata = (len_eff != '0) ? (rev_code(nxt_reg[len_idx]) >> rsh) : '0;

    // Bit packer
    assign mask_full   = ~({(CODE_W + 1){1'b1}} << len_eff);
    assign code_masked = (built_reg ? code_q_reg : '0) & mask_full[CODE_W-1:0];
    assign enc_acc     = ({{(BYTE_W - 1){1'b0}}, code_masked} << fill_reg)
                       | {{(CODE_W - 1){1'b0}}, buf_reg};
    assign enc_total   = TOT_W'(fill_reg) + TOT_W'(len_eff);
    assign enc_nb      = enc_total[TOT_W-1:FILL_W];
    assign enc_shift   = enc_acc >> {enc_nb, {FILL_W{1'b0}}};

    assign push           = cmd.emit || cmd.resp_push;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.enc_single = (len_eff == '0) || (enc_nb == '0);
    assign sts.rem_one    = (rem_reg == NB_W'(1));

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_bv_reg;
    assign out_status     = out_status_reg;
    assign out_last       = out_last_reg;

    // Memories
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[in_symbol] <= in_code_length;
        end
        if (cmd.asn_en) begin
            code_mem[addr_q_reg] <= code_wdata;
        end
        len_q_reg     <= len_mem[rd_addr];
        code_q_reg    <= code_mem[rd_addr];
        len_vld_q_reg <= len_vld_reg[rd_addr];
        addr_q_reg    <= rd_addr;
    end

    // Length counts and next codes
    always_ff @(posedge aclk) begin
        if (cmd.accept && (in_op == OP_BUILD)) begin
            cnt_reg <= '{default: '0};
        end else if (cmd.cnt_en && (len_eff != '0)) begin
            cnt_reg[len_idx] <= cnt_reg[len_idx] + CNT_W'(1);
        end
        if (cmd.sum_en) begin
            nxt_reg[sum_k] <= sum_val;
            run_reg        <= sum_val;
        end else if (cmd.asn_en && (len_eff != '0)) begin
            nxt_reg[len_idx] <= nxt_reg[len_idx] + CODE_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_vld_reg   <= '0;
            built_reg     <= 1'b0;
            buf_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (len_we) begin
                len_vld_reg[in_symbol] <= 1'b1;
            end
            if (cmd.asn_en) begin
                built_reg <= 1'b1;
            end
            if (cmd.accept && (in_op == OP_FLUSH)) begin
                buf_reg  <= '0;
                fill_reg <= '0;
            end else if (cmd.enc_calc && (len_eff != '0)) begin
                buf_reg  <= enc_shift[BYTE_W-1:0];
                fill_reg <= enc_total[FILL_W-1:0];
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            resp_byte_reg   <= ((in_op == OP_FLUSH) && (fill_reg != '0)) ? buf_reg : '0;
            resp_bv_reg     <= (in_op == OP_FLUSH) && (fill_reg != '0);
            resp_status_reg <= ((in_op == OP_LOAD) && len_too_long) ? ST_LEN_REFUSED : ST_OK;
        end else if (cmd.enc_calc) begin
            resp_byte_reg   <= '0;
            resp_bv_reg     <= 1'b0;
            resp_status_reg <= (len_eff == '0) ? ST_NO_CODE : ST_OK;
            acc_reg         <= enc_acc;
            rem_reg         <= enc_nb;
        end else if (cmd.emit) begin
            acc_reg <= acc_reg >> BYTE_W;
            rem_reg <= rem_reg - NB_W'(1);
        end

        if (cmd.emit) begin
            out_byte_reg   <= acc_reg[BYTE_W-1:0];
            out_bv_reg     <= 1'b1;
            out_status_reg <= ST_OK;
            out_last_reg   <= sts.rem_one;
        end else if (cmd.resp_push) begin
            out_byte_reg   <= resp_byte_reg;
            out_bv_reg     <= resp_bv_reg;
            out_status_reg <= resp_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

endmodule

// ===== rtl/canonical_huffman_encoder.sv =====
`timescale 1ns / 1ps
// Top level of the canonical Huffman encoder: stream ports, controller and datapath.
//
// Each input word carries an opcode in s_tuser and a symbol and code length in s_tdata. A load
// word sets the code length of one byte symbol; lengths above 32 are refused with status 1 and
// leave the table unchanged. A build word gives every symbol with a nonzero length a canonical
// code (shorter codes first, equal lengths in symbol order), stored bit-reversed so that the
// first code bit is bit 0. An encode word appends the symbol's code to an eight-bit packer that
// fills from the least significant bit, and emits one output word per completed byte (one to
// four); if no byte completes, a single word with byte_valid clear is returned, and a symbol
// without a code gives status 2 and leaves the packer alone. A flush word emits the partial byte
// with its unused high bits zero, or a word with byte_valid clear when the packer is empty.
// Every input word yields at least one output word, and tlast marks the final one. The length
// and code tables share one registered read port, so a build sweeps the length table once to
// count lengths, forms the first code of each length one length at a time, and sweeps the
// table again to assign codes. A new input word is taken as soon as the last output word of
// the previous one has entered the output register, even if that word is still waiting for
// m_tready. After reset all lengths and codes read as zero without any clearing pass.
module canonical_huffman_encoder import chc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata fields from bit 0: symbol [7:0], code_length [13:8], zero padding [15:14]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0: opcode [1:0]
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata fields from bit 0: out_byte [7:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser fields from bit 0: byte_valid [0], status [2:1]
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    cmd_t              ctrl_cmd;
    sts_t              dp_sts;
    op_t               in_op;
    logic              out_byte_valid;
    status_t           out_status;
    logic [BYTE_W-1:0] out_byte;

    assign in_op   = op_t'(s_tuser);
    assign m_tdata = out_byte;
    assign m_tuser = {out_status, out_byte_valid};

    chc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .in_ready (s_tready),
        .sts      (dp_sts),
        .cmd      (ctrl_cmd)
    );

    chc_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctrl_cmd),
        .sts            (dp_sts),
        .in_op          (in_op),
        .in_symbol      (s_tdata[SYM_W-1:0]),
        .in_code_length (s_tdata[SYM_W+LEN_W-1:SYM_W]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .out_status     (out_status),
        .out_last       (m_tlast)
    );

    // A word without a byte is always the only result of its input word.
    a_nobyte_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("result without a byte is not marked last");

    // A refused length or a missing code never carries a byte.
    a_error_has_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] != ST_OK)) |-> !m_tuser[0])
        else $error("error result carries a byte");

    // The output register is only loaded when it is free.
    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.emit || ctrl_cmd.resp_push) |-> dp_sts.out_free)
        else $error("output register overwritten");

    // Load and flush words are answered before the next input word is taken.
    a_single_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && ((s_tuser == OP_LOAD) || (s_tuser == OP_FLUSH)))
        |=> !s_tready)
        else $error("input taken while a response is pending");

endmodule

// ===== tb/sv/canonical_huffman_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the canonical Huffman encoder: directed script, random phases and a model.
//
// The testbench drives command words into the slave stream and checks every word that leaves the
// master stream. It keeps its own copy of the length table, the code table, the per-length counts
// and the bit packer. Each accepted command is run through that model at the moment of the
// handshake, and the words that the model produces are queued. Each output word is then matched,
// field by field, against the oldest queued word.
//
// The run opens with a short directed script covering the following:
// - every opcode and the extremes of the symbol and length fields
// - refused lengths, and a build with no lengths loaded
// - an encode of a symbol that has no code
// - a 32-bit code that spills over four output bytes
// - flushes with a partly filled and with an empty packer
// - a load after a build, and colliding codes from oversubscribed lengths
// Where a row's answer is obvious it is written into the script. Every other row is left to the
// model.
//
// Random phases follow. Each phase loads a handful of lengths, builds, and then encodes mostly
// symbols that have codes, with flushes and some noise mixed in. Both sides of the block pause at
// random. Once, the receiver holds off for a long stretch so that the block backs up and stalls
// its input.
module canonical_huffman_encoder_tb;
    import chc_pkg::*;

    // One output word as the model predicts it
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        status_t    status;
        logic       last;
    } enc_word_t;

    // One row of the directed script; fixed rows carry their answer with them
    typedef struct packed {
        op_t        op;
        logic [7:0] sym;
        logic [5:0] len;
        logic       fixed;
        enc_word_t  want;
    } script_row_t;

    localparam enc_word_t W_OK      = '{8'h00, 1'b0, ST_OK, 1'b1};
    localparam enc_word_t W_REFUSED = '{8'h00, 1'b0, ST_LEN_REFUSED, 1'b1};
    localparam enc_word_t W_NO_CODE = '{8'h00, 1'b0, ST_NO_CODE, 1'b1};
    localparam enc_word_t W_MODEL   = '{8'h00, 1'b0, ST_OK, 1'b0};

    localparam int SCRIPT_LEN   = 26;
    localparam int RANDOM_WORDS = 280;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;

    localparam script_row_t DIRECTED_SCRIPT [SCRIPT_LEN] = '{
        '{OP_ENCODE, 8'd0,   6'd0,  1'b1, W_NO_CODE}, // nothing has a code after reset
        '{OP_FLUSH,  8'd0,   6'd0,  1'b1, W_OK},      // flush of an empty packer
        '{OP_LOAD,   8'd0,   6'd63, 1'b1, W_REFUSED}, // longest length field
        '{OP_LOAD,   8'd255, 6'd33, 1'b1, W_REFUSED}, // just over the limit
        '{OP_BUILD,  8'd0,   6'd0,  1'b1, W_OK},      // build with no lengths at all
        '{OP_ENCODE, 8'd255, 6'd0,  1'b1, W_NO_CODE}, // refused load left no length behind
        '{OP_LOAD,   8'd0,   6'd32, 1'b1, W_OK},      // longest legal length
        '{OP_LOAD,   8'd255, 6'd1,  1'b1, W_OK},
        '{OP_LOAD,   8'd128, 6'd2,  1'b1, W_OK},
        '{OP_LOAD,   8'd85,  6'd3,  1'b1, W_OK},
        '{OP_LOAD,   8'd170, 6'd4,  1'b1, W_OK},
        '{OP_BUILD,  8'd255, 6'd63, 1'b1, W_OK},
        '{OP_ENCODE, 8'd255, 6'd63, 1'b0, W_MODEL},
        '{OP_ENCODE, 8'd0,   6'd0,  1'b0, W_MODEL},   // 32-bit code, four bytes out
        '{OP_ENCODE, 8'd128, 6'd0,  1'b0, W_MODEL},
        '{OP_ENCODE, 8'd85,  6'd0,  1'b0, W_MODEL},
        '{OP_ENCODE, 8'd170, 6'd0,  1'b0, W_MODEL},
        '{OP_ENCODE, 8'd3,   6'd0,  1'b1, W_NO_CODE},
        '{OP_FLUSH,  8'd0,   6'd0,  1'b0, W_MODEL},   // partial byte with pending bits
        '{OP_FLUSH,  8'd255, 6'd63, 1'b1, W_OK},      // packer now empty
        '{OP_LOAD,   8'd85,  6'd6,  1'b1, W_OK},      // new length, old code: masked on encode
        '{OP_ENCODE, 8'd85,  6'd0,  1'b0, W_MODEL},
        '{OP_LOAD,   8'd1,   6'd1,  1'b1, W_OK},      // second 1-bit code oversubscribes
        '{OP_BUILD,  8'd0,   6'd0,  1'b1, W_OK},
        '{OP_ENCODE, 8'd1,   6'd0,  1'b0, W_MODEL},
        '{OP_FLUSH,  8'd0,   6'd0,  1'b0, W_MODEL}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = OP_LOAD;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Model state: loaded lengths, codes of the last build, counts per length, bit packer
    logic [LEN_W-1:0]  sym_len   [256];
    logic [CODE_W-1:0] sym_code  [256];
    logic [8:0]        len_count [33];
    logic [7:0]        pack_bits = '0;
    logic [2:0]        pack_fill = '0;

    enc_word_t fresh_words   [$];   // words that the latest command produces
    enc_word_t pending_words [$];   // words that the block still owes, oldest first

    bit tx_fast        = 1'b0;
    bit rx_fast        = 1'b0;
    bit held_off       = 1'b0;
    int words_sent     = 0;
    int builds_sent    = 0;
    int words_checked  = 0;
    int bytes_seen     = 0;
    int mismatches     = 0;

    canonical_huffman_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // A 2 ms ceiling is many times the slowest correct run, even with every build and stall.
    initial begin
        #2000000;
        $display("canonical_huffman_encoder test failed");
        $finish;
    end

    function automatic void note_word(logic [7:0] data, logic valid, status_t status,
                                      logic last);
        enc_word_t w;
        w = '{data, valid, status, last};
        fresh_words.insert(fresh_words.size(), w);
    endfunction

    // Counts the lengths, forms the first code of each length, and then hands out codes in
    // symbol order. Each code is stored bit-reversed within its own length.
    function automatic void assign_canonical_codes();
        logic [63:0] first_code [33];
        logic [63:0] rev;
        int l;
        int s;
        int i;
        for (l = 0; l <= 32; l++) len_count[l] = '0;
        for (s = 0; s < NUM_SYMBOLS && s < 256; s++) begin
            l = sym_len[s];
            if (l >= 1 && l <= LEN_LIMIT) len_count[l]++;
        end
        first_code[0] = '0;
        for (l = 1; l <= 32; l++) begin
            first_code[l] = (first_code[l-1] + ((l >= 2) ? 64'(len_count[l-1]) : 64'd0)) << 1;
        end
        for (s = 0; s < 256; s++) begin
            l = sym_len[s];
            if (s < NUM_SYMBOLS && l >= 1 && l <= LEN_LIMIT) begin
                rev = '0;
                for (i = 0; i < l; i++) rev[l-1-i] = first_code[l][i];
                sym_code[s] = rev[CODE_W-1:0];
                first_code[l]++;
            end else begin
                sym_code[s] = '0;
            end
        end
    endfunction

    // Advances the model by one command and leaves the words that it owes in fresh_words.
    function automatic void predict_encoder_words(op_t op, logic [7:0] sym, logic [5:0] len);
        logic [63:0] code;
        logic [63:0] acc;
        int l;
        int total;
        int n;
        fresh_words.delete();
        case (op)
            OP_LOAD: begin
                if (len > LEN_LIMIT) begin
                    note_word(8'h00, 1'b0, ST_LEN_REFUSED, 1'b1);
                end else begin
                    if (sym < NUM_SYMBOLS) sym_len[sym] = len;
                    note_word(8'h00, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_BUILD: begin
                assign_canonical_codes();
                note_word(8'h00, 1'b0, ST_OK, 1'b1);
            end
            OP_ENCODE: begin
                l = (sym < NUM_SYMBOLS) ? int'(sym_len[sym]) : 0;
                if (l == 0 || l > LEN_LIMIT) begin
                    note_word(8'h00, 1'b0, ST_NO_CODE, 1'b1);
                end else begin
                    code  = {32'd0, sym_code[sym]} & ((64'd1 << l) - 64'd1);
                    acc   = {56'd0, pack_bits} | (code << pack_fill);
                    total = int'(pack_fill) + l;
                    n     = 0;
                    while (total >= 8 && n < 4) begin
                        note_word(acc[7:0], 1'b1, ST_OK, 1'b0);
                        acc   = acc >> 8;
                        total = total - 8;
                        n++;
                    end
                    pack_bits = acc[7:0];
                    pack_fill = total[2:0];
                    if (n == 0) note_word(8'h00, 1'b0, ST_OK, 1'b1);
                    else fresh_words[fresh_words.size()-1].last = 1'b1;
                end
            end
            default: begin
                if (pack_fill != 0) begin
                    note_word(pack_bits, 1'b1, ST_OK, 1'b1);
                    pack_bits = '0;
                    pack_fill = '0;
                end else begin
                    note_word(8'h00, 1'b0, ST_OK, 1'b1);
                end
            end
        endcase
    endfunction

    // Offers one command word and waits for the handshake. Valid is left high afterwards, so
    // that a back-to-back word costs no idle cycle. The next call lowers it only when it
    // draws a gap. A fixed row replaces the model's answer with the one written in the script,
    // while the model still advances.
    task automatic offer_word(op_t op, logic [7:0] sym, logic [5:0] len, logic fixed,
                              enc_word_t want);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, len, sym};
        do @(posedge aclk); while (!s_tready);
        predict_encoder_words(op, sym, len);
        if (fixed) begin
            pending_words.insert(pending_words.size(), want);
        end else begin
            foreach (fresh_words[k]) pending_words.insert(pending_words.size(), fresh_words[k]);
        end
        words_sent++;
        if (op == OP_BUILD) builds_sent++;
    endtask

    function automatic logic [7:0] pick_coded_symbol();
        logic [7:0] pool [$];
        int s;
        for (s = 0; s < 256; s++) if (sym_len[s] != 0) pool.insert(pool.size(), s[7:0]);
        if (pool.size() == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Short codes are the common case. The tail covers long codes, clearing a symbol, and
    // refused lengths.
    function automatic logic [5:0] draw_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 6'($urandom_range(1, 8));
        if (r < 15) return 6'($urandom_range(9, 16));
        if (r < 17) return 6'($urandom_range(17, 32));
        if (r == 17) return 6'd0;
        return 6'($urandom_range(33, 63));
    endfunction

    // Checker: each accepted output word is compared with the oldest word still owed.
    always @(posedge aclk) begin
        enc_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (m_tuser[0]) bytes_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output word with nothing owed: byte %h user %b last %b",
                             $realtime, m_tdata, m_tuser, m_tlast);
            end else begin
                exp_w = pending_words.pop_front();
                if (m_tdata !== exp_w.data || m_tuser[0] !== exp_w.byte_valid ||
                    m_tuser[2:1] !== exp_w.status || m_tlast !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("%0t: word mismatch: expected byte %h valid %b status %0d last %b, ",
                               $realtime, exp_w.data, exp_w.byte_valid, exp_w.status,
                               exp_w.last);
                        $display("got byte %h valid %b status %0d last %b",
                                 m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
                    end
                end
            end
        end
    end

    // Receiver: a random pause before each word, with spells of no pausing. Once, it holds off
    // for a long stretch so that the output register fills and the block refuses input.
    initial begin
        int gap;
        int served;
        served = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (served % 25 == 0) rx_fast = ($urandom_range(0, 3) == 0);
            if (!held_off && words_checked >= 100) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = rx_fast ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            served++;
        end
    end

    // Sender: reset, the directed script, the random phases, then draining and the verdict.
    initial begin
        int nloads;
        int nenc;
        int r;
        int random_sent;
        for (int s = 0; s < 256; s++) begin
            sym_len[s]  = '0;
            sym_code[s] = '0;
        end
        for (int l = 0; l <= 32; l++) len_count[l] = '0;
        random_sent = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_SCRIPT[i])
            offer_word(DIRECTED_SCRIPT[i].op, DIRECTED_SCRIPT[i].sym, DIRECTED_SCRIPT[i].len,
                       DIRECTED_SCRIPT[i].fixed, DIRECTED_SCRIPT[i].want);

        // Each phase is a well-formed table load and build followed by a run of encodes. The
        // noise words may be of any kind, including stray loads after the build.
        while (random_sent < RANDOM_WORDS) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            nloads  = $urandom_range(3, 12);
            repeat (nloads) begin
                offer_word(OP_LOAD, 8'($urandom_range(0, 255)), draw_length(), 1'b0, W_MODEL);
                random_sent++;
            end
            offer_word(OP_BUILD, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                       1'b0, W_MODEL);
            random_sent++;
            nenc = $urandom_range(15, 40);
            repeat (nenc) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    offer_word(OP_ENCODE, pick_coded_symbol(), 6'($urandom_range(0, 63)),
                               1'b0, W_MODEL);
                else if (r == 7)
                    offer_word(OP_FLUSH, 8'($urandom_range(0, 255)),
                               6'($urandom_range(0, 63)), 1'b0, W_MODEL);
                else if (r == 8)
                    offer_word(OP_ENCODE, 8'($urandom_range(0, 255)),
                               6'($urandom_range(0, 63)), 1'b0, W_MODEL);
                else
                    offer_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               6'($urandom_range(0, 63)), 1'b0, W_MODEL);
                random_sent++;
            end
            if ($urandom_range(0, 1) == 1) begin
                offer_word(OP_FLUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                           1'b0, W_MODEL);
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Wait until every owed word has arrived, then give the block time to show any
        // surplus word.
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d command words (%0d from the script, %0d builds).",
                 words_sent, SCRIPT_LEN, builds_sent);
        $display("Checked %0d output words, %0d of them bytes, with %0d mismatches.",
                 words_checked, bytes_seen, mismatches);
        if (mismatches == 0)
            $display("canonical_huffman_encoder test passed");
        else
            $display("canonical_huffman_encoder test failed");
        $finish;
    end

endmodule
